// File: sv/rsc_pkg.sv
// Shared types and constants for the RPN stack calculator.
// Holds the command and status codes and the controller/datapath interface structs.
// Depends on nothing.
package rsc_pkg;

	localparam int DEFAULT_STACK_DEPTH = 16;

	localparam int DATA_W     = 32;
	localparam int MODE_W     = 3;
	localparam int STATUS_W   = 2;
	localparam int DEPTH_W    = 5;
	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 40;
	localparam int M_PAD_W    = M_TDATA_W - DATA_W - DEPTH_W;
	localparam int DIV_STEP_W = $clog2(DATA_W);

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH = 3'd0,
		MODE_POP  = 3'd1,
		MODE_ADD  = 3'd2,
		MODE_SUB  = 3'd3,
		MODE_MUL  = 3'd4,
		MODE_DIV  = 3'd5
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_UNDER   = 2'd1,
		ST_DIVZERO = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EXEC,
		S_DIV,
		S_RESP
	} state_t;

	typedef struct packed {
		logic load_item;
		logic read;
		logic exec;
		logic div_commit;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic div_go;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

// File: sv/rpn_stack_calculator_unit.sv
// RPN stack calculator top level: one command beat in, one result beat out.
// Each command passes the read, execute and response states; a divide also waits in the
// divide state on the one-bit-per-cycle divider, and a busy output register stalls the response.
// One command is in flight at a time, so a new beat is taken only once the last one's result
// has been loaded. A finished result may wait in the output register while the next command runs.
// Asynchronous active-low reset empties the stack; stack memory contents are not cleared.
module rpn_stack_calculator_unit #(
	parameter int STACK_DEPTH = rsc_pkg::DEFAULT_STACK_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [rsc_pkg::S_TDATA_W-1:0]  s_tdata,  // [31:0] operand
	input  logic [rsc_pkg::MODE_W-1:0]     s_tuser,  // [2:0] mode
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [rsc_pkg::M_TDATA_W-1:0]  m_tdata,  // [31:0] value, [36:32] depth, rest zero
	output logic [rsc_pkg::STATUS_W-1:0]   m_tuser   // [1:0] status
);
	import rsc_pkg::*;

	cmd_t                cmd;
	sts_t                sts;
	logic [DATA_W-1:0]   out_value;
	logic [DEPTH_W-1:0]  out_depth;

	rsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rsc_datapath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.item_mode    (s_tuser),
		.item_operand (s_tdata[DATA_W-1:0]),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_status   (m_tuser),
		.out_value    (out_value),
		.out_depth    (out_depth)
	);

	assign m_tdata = {M_PAD_W'(0), out_depth, out_value};

`ifndef SYNTHESIS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input beat taken while a command is in flight");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!m_tvalid || m_tready))
		else $error("result overwrites a beat not yet taken");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_OK) |-> (m_tdata[DATA_W-1:0] == '0))
		else $error("error status with nonzero value");
`endif

endmodule

// File: sv/rsc_div.sv
// Radix-2 restoring divider for signed 32-bit operands, quotient truncated toward zero.
// One quotient bit per cycle; the result holds until the next start.
// Depends on rsc_pkg.
module rsc_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [rsc_pkg::DATA_W-1:0] dividend,
	input  logic [rsc_pkg::DATA_W-1:0] divisor,
	output logic                      done,
	output logic [rsc_pkg::DATA_W-1:0] quotient
);
	import rsc_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_STEP_W-1:0] step_q;
	logic [DATA_W-1:0]     rem_q;
	logic [DATA_W-1:0]     quo_q;
	logic [DATA_W-1:0]     den_q;
	logic                  neg_q;
	logic [DATA_W:0]       shifted;
	logic [DATA_W:0]       trial;
	logic [DATA_W-1:0]     mag_n;
	logic [DATA_W-1:0]     mag_d;

	assign mag_n   = dividend[DATA_W-1] ? (DATA_W'(0) - dividend) : dividend;
	assign mag_d   = divisor[DATA_W-1] ? (DATA_W'(0) - divisor) : divisor;
	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '1;
			end else if (busy_q) begin
				step_q <= step_q - DIV_STEP_W'(1);
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= mag_n;
			den_q <= mag_d;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
		end else if (busy_q) begin
			// A clear top bit of the trial difference means the divisor fits.
			if (!trial[DATA_W]) begin
				rem_q <= trial[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (DATA_W'(0) - quo_q) : quo_q;

endmodule

// File: sv/rsc_datapath.sv
// Datapath of the RPN stack calculator: stack memory, stack count, ALU,
// divider and the output register. Driven by commands from rsc_ctrl.
// Depends on rsc_pkg and rsc_div.
module rsc_datapath #(
	parameter int STACK_DEPTH = rsc_pkg::DEFAULT_STACK_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rsc_pkg::cmd_t                 cmd,
	output rsc_pkg::sts_t                 sts,
	input  logic [rsc_pkg::MODE_W-1:0]    item_mode,
	input  logic [rsc_pkg::DATA_W-1:0]    item_operand,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rsc_pkg::STATUS_W-1:0]  out_status,
	output logic [rsc_pkg::DATA_W-1:0]    out_value,
	output logic [rsc_pkg::DEPTH_W-1:0]   out_depth
);
	import rsc_pkg::*;

	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);

	logic [DATA_W-1:0]   mem [STACK_DEPTH];

	logic [MODE_W-1:0]   mode_q;
	logic [DATA_W-1:0]   operand_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DATA_W-1:0]   rd_top_q;
	logic [DATA_W-1:0]   rd_sec_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [DATA_W-1:0]   res_value_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [DATA_W-1:0]   out_value_q;
	logic [DEPTH_W-1:0]  out_depth_q;

	logic [CNT_W-1:0]    cnt_m1;
	logic [CNT_W-1:0]    cnt_m2;
	logic [CNT_W-1:0]    exec_cnt;
	logic [STATUS_W-1:0] exec_status;
	logic [DATA_W-1:0]   exec_value;
	logic                exec_we;
	logic                exec_at_sec;
	logic                div_go;
	logic                div_done;
	logic [DATA_W-1:0]   div_quo;
	logic                wr_en;
	logic [ADDR_W-1:0]   wr_addr;
	logic [DATA_W-1:0]   wr_data;

	assign cnt_m1 = cnt_q - CNT_W'(1);
	assign cnt_m2 = cnt_q - CNT_W'(2);

	always_comb begin
		exec_cnt    = cnt_q;
		exec_status = ST_OK;
		exec_value  = '0;
		exec_we     = 1'b0;
		exec_at_sec = 1'b0;
		div_go      = 1'b0;
		unique case (mode_q)
			MODE_PUSH: begin
				if (cnt_q >= CNT_W'(STACK_DEPTH)) begin
					exec_status = ST_FULL;
				end else begin
					exec_we    = 1'b1;
					exec_value = operand_q;
					exec_cnt   = cnt_q + CNT_W'(1);
				end
			end
			MODE_POP: begin
				if (cnt_q == '0) begin
					exec_status = ST_UNDER;
				end else begin
					exec_value = rd_top_q;
					exec_cnt   = cnt_m1;
				end
			end
			MODE_ADD, MODE_SUB, MODE_MUL: begin
				if (cnt_q < CNT_W'(2)) begin
					exec_status = ST_UNDER;
				end else begin
					case (mode_q)
						MODE_ADD: exec_value = rd_top_q + rd_sec_q;
						MODE_SUB: exec_value = rd_top_q - rd_sec_q;
						default:  exec_value = DATA_W'(rd_top_q * rd_sec_q);
					endcase
					exec_we     = 1'b1;
					exec_at_sec = 1'b1;
					exec_cnt    = cnt_m1;
				end
			end
			MODE_DIV: begin
				if (cnt_q < CNT_W'(2)) begin
					exec_status = ST_UNDER;
				end else if (rd_sec_q == '0) begin
					exec_status = ST_DIVZERO;
				end else begin
					div_go = 1'b1;
				end
			end
			default: begin
				// Unused command codes leave the stack alone and report ok.
			end
		endcase
	end

	rsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.exec && div_go),
		.dividend (rd_top_q),
		.divisor  (rd_sec_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q[ADDR_W-1:0];
		wr_data = operand_q;
		if (cmd.div_commit) begin
			wr_en   = 1'b1;
			wr_addr = cnt_m2[ADDR_W-1:0];
			wr_data = div_quo;
		end else if (cmd.exec && exec_we) begin
			wr_en   = 1'b1;
			wr_addr = exec_at_sec ? cnt_m2[ADDR_W-1:0] : cnt_q[ADDR_W-1:0];
			wr_data = exec_value;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.read) begin
			rd_top_q <= mem[cnt_m1[ADDR_W-1:0]];
			rd_sec_q <= mem[cnt_m2[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			mode_q    <= item_mode;
			operand_q <= item_operand;
		end
		if (cmd.exec) begin
			res_status_q <= exec_status;
			res_value_q  <= exec_value;
		end else if (cmd.div_commit) begin
			res_value_q <= div_quo;
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_value_q  <= res_value_q;
			out_depth_q  <= DEPTH_W'(cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				cnt_q <= exec_cnt;
			end else if (cmd.div_commit) begin
				cnt_q <= cnt_m1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.div_go   = div_go;
	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_value  = out_value_q;
	assign out_depth  = out_depth_q;

endmodule

// File: sv/rsc_ctrl.sv
// Controller of the RPN stack calculator: sequences read, execute,
// divide and response for one command at a time.
// Depends on rsc_pkg.
module rsc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rsc_pkg::sts_t sts,
	output rsc_pkg::cmd_t cmd
);
	import rsc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		in_ready       = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_READ;
				end
			end
			S_READ: begin
				cmd.read = 1'b1;
				state_d  = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.div_go ? S_DIV : S_RESP;
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.div_commit = 1'b1;
					state_d        = S_RESP;
				end
			end
			S_RESP: begin
				// Hold the result until the output register can take it.
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: tb/rpn_stack_calculator_unit_test.sv
// Self-checking testbench for rpn_stack_calculator_unit: command beats in, result beats out.
// A scoreboard class keeps its own copy of the operand stack to predict each result.
// Depends on rsc_pkg and the rpn_stack_calculator_unit RTL.
module rpn_stack_calculator_unit_test;
	import rsc_pkg::*;

	localparam int DEPTH        = DEFAULT_STACK_DEPTH;
	localparam int IDLE_LIMIT   = 4000;
	localparam int RANDOM_ITEMS = 1600;

	localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;
	localparam logic [DATA_W-1:0] INT_MIN     = 32'h8000_0000;
	localparam logic [DATA_W-1:0] INT_MAX     = 32'h7fff_ffff;
	localparam logic [DATA_W-1:0] MINUS_ONE   = 32'hffff_ffff;

	typedef struct {
		status_t            status;
		logic [DATA_W-1:0]  value;
		logic [DEPTH_W-1:0] depth;
	} calc_result_t;

	class calc_scoreboard;
		logic [DATA_W-1:0] slots [DEPTH];
		int unsigned       fill;
		calc_result_t      awaited [$];
		int                errors;

		function new();
			fill   = 0;
			errors = 0;
		endfunction

		// Signed division truncated toward zero, done on magnitudes.
		function logic [DATA_W-1:0] quotient(logic [DATA_W-1:0] top, logic [DATA_W-1:0] sec);
			logic [DATA_W-1:0] mag_t;
			logic [DATA_W-1:0] mag_s;
			logic [DATA_W-1:0] q;
			mag_t = top[DATA_W-1] ? (32'd0 - top) : top;
			mag_s = sec[DATA_W-1] ? (32'd0 - sec) : sec;
			q = mag_t / mag_s;
			return (top[DATA_W-1] != sec[DATA_W-1]) ? (32'd0 - q) : q;
		endfunction

		function void note_command(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] operand);
			calc_result_t      r;
			logic [DATA_W-1:0] top;
			logic [DATA_W-1:0] sec;
			logic [DATA_W-1:0] res;
			r.status = ST_OK;
			r.value  = '0;
			case (mode)
				MODE_PUSH: begin
					if (fill >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						slots[fill] = operand;
						fill++;
						r.value = operand;
					end
				end
				MODE_POP: begin
					if (fill == 0) begin
						r.status = ST_UNDER;
					end else begin
						fill--;
						r.value = slots[fill];
					end
				end
				MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
					if (fill < 2) begin
						r.status = ST_UNDER;
					end else begin
						top = slots[fill-1];
						sec = slots[fill-2];
						if (mode == MODE_DIV && sec == '0) begin
							// Both operands stay where they are.
							r.status = ST_DIVZERO;
						end else begin
							case (mode)
								MODE_ADD: res = top + sec;
								MODE_SUB: res = top - sec;
								MODE_MUL: res = top * sec;
								default:  res = quotient(top, sec);
							endcase
							fill--;
							slots[fill-1] = res;
							r.value = res;
						end
					end
				end
				default: ;
			endcase
			r.depth = fill[DEPTH_W-1:0];
			awaited = {awaited, r};
		endfunction

		function void check_result(logic [STATUS_W-1:0] status, logic [M_TDATA_W-1:0] tdata);
			calc_result_t e;
			if (awaited.size() == 0) begin
				$error("result beat with nothing pending: status %0d tdata %h", status, tdata);
				errors++;
				return;
			end
			e = awaited.pop_front();
			if (status !== e.status) begin
				$error("status: expected %0d, actual %0d", e.status, status);
				errors++;
			end
			if (tdata[DATA_W-1:0] !== e.value) begin
				$error("value: expected %0d, actual %0d", $signed(e.value),
					$signed(tdata[DATA_W-1:0]));
				errors++;
			end
			if (tdata[DATA_W+DEPTH_W-1:DATA_W] !== e.depth) begin
				$error("depth: expected %0d, actual %0d", e.depth,
					tdata[DATA_W+DEPTH_W-1:DATA_W]);
				errors++;
			end
			if (tdata[M_TDATA_W-1:DATA_W+DEPTH_W] !== '0) begin
				$error("pad: expected 0, actual %0d", tdata[M_TDATA_W-1:DATA_W+DEPTH_W]);
				errors++;
			end
		endfunction

		function int unsigned depth();
			return fill;
		endfunction

		function int unsigned pending();
			return awaited.size();
		endfunction
	endclass

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata  = '0;
	logic [MODE_W-1:0]     s_tuser  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [STATUS_W-1:0]   m_tuser;

	calc_scoreboard sb;
	bit             calm;
	int unsigned    issued;

	rpn_stack_calculator_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one; none at all in calm stretches.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	function automatic logic [DATA_W-1:0] pick_operand();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return 32'd1;
			2:       return MINUS_ONE;
			3:       return INT_MIN;
			4:       return INT_MAX;
			5, 6:    return 32'($urandom_range(0, 40)) - 32'd20;
			default: return $urandom();
		endcase
	endfunction

	// Commands that keep the stack mostly between two entries and full.
	function automatic logic [MODE_W-1:0] pick_mode(int unsigned depth);
		int r;
		r = $urandom_range(0, 99);
		if (depth < 2) begin
			if (r < 80)
				return MODE_PUSH;
			return 3'($urandom_range(int'(MODE_POP), int'(MODE_DIV)));
		end
		if (depth >= DEPTH && r < 85)
			return 3'($urandom_range(int'(MODE_POP), int'(MODE_DIV)));
		if (r < 40)
			return MODE_PUSH;
		if (r < 50)
			return MODE_POP;
		return 3'($urandom_range(int'(MODE_ADD), int'(MODE_DIV)));
	endfunction

	task automatic send_command(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] operand);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= operand;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		sb.note_command(mode, operand);
		if (mode <= MODE_DIV)
			issued++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Result side: check every accepted beat, then choose ready for the next cycle.
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_result(m_tuser, m_tdata);
			if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 2) == 0)
					stall = pick_gap();
			end
		end
	end

	initial begin
		int idle;
		idle = 0;
		@(posedge arst_n);
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$display("rpn_stack_calculator_unit regression: fail");
		$finish;
	end

	initial begin
		bit paused;
		sb     = new();
		calm   = 1'b0;
		issued = 0;
		paused = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty stack, then a lone entry that arithmetic must leave alone.
		send_command(MODE_POP, INT_MAX);
		send_command(MODE_ADD, '0);
		send_command(MODE_PUSH, INT_MIN);
		send_command(MODE_DIV, '0);
		send_command(MODE_POP, '0);
		send_command(MODE_PUSH, '0);
		send_command(MODE_MUL, '0);
		// Zero divisor below the top, then wraparound cases.
		send_command(MODE_PUSH, 32'd7);
		send_command(MODE_DIV, '0);
		send_command(MODE_SUB, '0);
		send_command(MODE_PUSH, INT_MAX);
		send_command(MODE_ADD, '0);
		send_command(MODE_PUSH, MINUS_ONE);
		send_command(MODE_PUSH, INT_MIN);
		send_command(MODE_DIV, '0);
		send_command(MODE_MUL, '0);
		send_command(MODE_PUSH, 32'd2);
		send_command(MODE_PUSH, 32'hffff_fff9);
		send_command(MODE_DIV, '0);
		send_command(MODE_SPARE6, INT_MAX);
		send_command(MODE_SPARE7, MINUS_ONE);
		send_command(MODE_POP, '0);
		send_command(MODE_POP, '0);
		send_command(MODE_POP, '0);

		while (issued < 24 + RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 5) == 0);
			case ($urandom_range(0, 19))
				0: begin
					while (sb.depth() < DEPTH)
						send_command(MODE_PUSH, pick_operand());
					repeat ($urandom_range(1, 3))
						send_command(MODE_PUSH, $urandom());
				end
				1: begin
					while (sb.depth() > 0)
						send_command(MODE_POP, $urandom());
					repeat ($urandom_range(1, 2))
						send_command(MODE_POP, $urandom());
				end
				2: begin
					send_command(MODE_PUSH, '0);
					send_command(MODE_PUSH, pick_operand());
					send_command(MODE_DIV, $urandom());
				end
				3: begin
					repeat ($urandom_range(1, 4))
						send_command(3'($urandom_range(0, 7)), $urandom());
				end
				default: begin
					repeat ($urandom_range(4, 16))
						send_command(pick_mode(sb.depth()), pick_operand());
				end
			endcase
			// Hold the sender once until every pending result is out.
			if (!paused && issued > 800) begin
				paused = 1'b1;
				drain_results();
			end
		end

		drain_results();
		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("rpn_stack_calculator_unit regression: pass");
		else
			$display("rpn_stack_calculator_unit regression: fail");
		$finish;
	end
endmodule
